// ----- design/msss_pkg.sv -----
// ----------------------------------------------------------------------------
// msss_pkg: shared types and codes for the substring search block
// Item and result structs, opcode and register codes, default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package msss_pkg;

  localparam int MAX_PATTERN_LEN_DEF = 32;
  localparam int MAX_CONDS_DEF       = 4;

  // item opcodes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_LEN  = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_CASE   = 2'd0;
  localparam logic [1:0] CFG_BACK   = 2'd1;
  localparam logic [1:0] CFG_VCOUNT = 2'd2;
  localparam logic [1:0] CFG_RSTART = 2'd3;

  localparam logic [5:0] LEN_RESET = 6'd63;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] variant_index;
    logic [4:0] char_index;
    logic [7:0] exact_char;
    logic [7:0] upper_char;
    logic [7:0] lower_char;
    logic [5:0] variant_length;
    logic [7:0] data_byte;
    logic       data_missing;
    logic       range_last;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_offset;
    logic [5:0]  match_length;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic set_len;
    logic data;
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    in_item_t  item;
  } cmd_t;

  typedef struct packed {
    logic        case_sensitive;
    logic        search_backward;
    logic [2:0]  variant_count;
    logic [31:0] range_start;
  } cfg_t;

endpackage

`default_nettype wire

// ----- design/msss_front.sv -----
// ----------------------------------------------------------------------------
// msss_front: input side
// Accepts items, decodes the opcode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module msss_front import msss_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  output logic          cmd_valid,
  output cmd_t          cmd,
  input  wire logic     cmd_take
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;
  cmd_t       dec;

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_comb begin
    dec.item         = in_item;
    dec.kind.load    = (in_item.opcode == OP_LOAD);
    dec.kind.set_len = (in_item.opcode == OP_LEN);
    dec.kind.data    = (in_item.opcode == OP_DATA);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ----- design/msss_back.sv -----
// ----------------------------------------------------------------------------
// msss_back: search engine and result queue
// Pattern store, alignment cells, best-match tracking, two-entry result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module msss_back import msss_pkg::*; #(
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
  parameter int MAX_CONDS       = MAX_CONDS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  cmd_valid,
  input  wire cmd_t  cmd,
  output logic       cmd_take,
  output logic       empty,
  input  wire logic  pop,
  output out_item_t  out_item
);

  localparam int DW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int CW = (DW > 6) ? DW + 1 : 7;
  localparam int L  = MAX_PATTERN_LEN;

  logic [7:0] exact_r [MAX_CONDS][L];
  logic [7:0] upper_r [MAX_CONDS][L];
  logic [7:0] lower_r [MAX_CONDS][L];
  logic [5:0] len_r   [MAX_CONDS];

  logic [L-1:0] alive_r, alive_nxt;
  logic [31:0]  pos_r, pos_nxt;
  logic [31:0]  bstart_r, bstart_nxt;
  logic [5:0]   blen_r, blen_nxt;
  logic         done_r, done_nxt;

  out_item_t    oq_r [2];
  logic         owr_r, ord_r;
  logic [1:0]   ocnt_r;
  logic         ofull;
  logic         res_push;
  out_item_t    res;

  logic [L-1:0] live, lastv, contv;
  logic         is_data;

  assign ofull    = (ocnt_r == 2'd2);
  assign is_data  = cmd.kind.data;
  assign cmd_take = cmd_valid && !(is_data && ofull);
  assign empty    = (ocnt_r == 2'd0);
  assign out_item = oq_r[ord_r];

  // pattern store: each cell reads its own column
  always_ff @(posedge clk) begin
    if (cmd_take && cmd.kind.load) begin
      for (int v = 0; v < MAX_CONDS; v++) begin
        for (int c = 0; c < L; c++) begin
          if ({30'd0, cmd.item.variant_index} == 32'(v) &&
              {27'd0, cmd.item.char_index} == 32'(c)) begin
            exact_r[v][c] <= cmd.item.exact_char;
            upper_r[v][c] <= cmd.item.upper_char;
            lower_r[v][c] <= cmd.item.lower_char;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < MAX_CONDS; v++) len_r[v] <= LEN_RESET;
    end else if (cmd_take && cmd.kind.set_len) begin
      for (int v = 0; v < MAX_CONDS; v++) begin
        if ({30'd0, cmd.item.variant_index} == 32'(v)) begin
          len_r[v] <= cmd.item.variant_length;
        end
      end
    end
  end

  // per-cell classing: first eligible matching variant decides
  always_comb begin
    logic          decided;
    logic          hit;
    logic [CW-1:0] dd, ll;
    for (int d = 0; d < L; d++) begin
      live[d]  = (d == 0) ? (cfg.search_backward || blen_r == 6'd0) : alive_r[d-1];
      lastv[d] = 1'b0;
      contv[d] = 1'b0;
      decided  = 1'b0;
      dd       = CW'(d);
      for (int v = 0; v < MAX_CONDS; v++) begin
        ll  = {{(CW-6){1'b0}}, len_r[v]};
        hit = cfg.case_sensitive ? (exact_r[v][d] == cmd.item.data_byte)
                                 : (upper_r[v][d] == cmd.item.data_byte ||
                                    lower_r[v][d] == cmd.item.data_byte);
        if (!decided && 32'(v) < {29'd0, cfg.variant_count} &&
            len_r[v] != 6'd0 && dd < ll && hit) begin
          decided = 1'b1;
          if (dd == ll - CW'(1)) lastv[d] = live[d];
          else                   contv[d] = live[d];
        end
      end
    end
  end

  // one data step
  always_comb begin
    logic          hit;
    logic [DW-1:0] hd;
    logic [31:0]   s;
    alive_nxt  = alive_r;
    pos_nxt    = pos_r;
    bstart_nxt = bstart_r;
    blen_nxt   = blen_r;
    done_nxt   = done_r;
    res_push   = 1'b0;
    res        = '0;
    hit        = 1'b0;
    hd         = '0;
    s          = '0;
    if (cmd_take && is_data) begin
      if (done_r) begin
        if (cmd.item.range_last) begin
          alive_nxt = '0; pos_nxt = '0; bstart_nxt = '0; blen_nxt = '0;
          done_nxt  = 1'b0;
        end
      end else if (cmd.item.data_missing) begin
        if (!cfg.search_backward) begin
          res_push = 1'b1;
          if (cmd.item.range_last) begin
            alive_nxt = '0; pos_nxt = '0; bstart_nxt = '0; blen_nxt = '0;
          end else begin
            done_nxt = 1'b1;
          end
        end else begin
          alive_nxt  = '0;
          bstart_nxt = '0;
          blen_nxt   = '0;
          pos_nxt    = pos_r + 32'd1;
          if (cmd.item.range_last) begin
            res_push = 1'b1;
            pos_nxt  = '0;
          end
        end
      end else begin
        if (!cfg.search_backward) begin
          // earliest start wins: highest cell offset
          for (int d = 0; d < L; d++) begin
            if (lastv[d]) begin hit = 1'b1; hd = DW'(d); end
          end
        end else begin
          for (int d = L - 1; d >= 0; d--) begin
            if (lastv[d]) begin hit = 1'b1; hd = DW'(d); end
          end
        end
        s = pos_r - {{(32-DW){1'b0}}, hd};
        if (hit && (!cfg.search_backward || blen_r == 6'd0 || s > bstart_r)) begin
          bstart_nxt = s;
          blen_nxt   = 6'({{(CW-DW){1'b0}}, hd} + CW'(1));
        end
        for (int d = 0; d < L; d++) begin
          alive_nxt[d] = contv[d] && (d < L - 1) &&
                         !(!cfg.search_backward && hit && DW'(d) < hd);
        end
        pos_nxt = pos_r + 32'd1;
        if (cmd.item.range_last) begin
          res_push           = 1'b1;
          res.found          = (blen_nxt != 6'd0);
          res.match_offset   = (blen_nxt != 6'd0) ? cfg.range_start + bstart_nxt : 32'd0;
          res.match_length   = blen_nxt;
          alive_nxt = '0; pos_nxt = '0; bstart_nxt = '0; blen_nxt = '0;
        end else if (!cfg.search_backward && blen_nxt != 6'd0 && alive_nxt == '0) begin
          res_push         = 1'b1;
          res.found        = 1'b1;
          res.match_offset = cfg.range_start + bstart_nxt;
          res.match_length = blen_nxt;
          done_nxt         = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r  <= '0;
      pos_r    <= '0;
      bstart_r <= '0;
      blen_r   <= '0;
      done_r   <= 1'b0;
    end else begin
      alive_r  <= alive_nxt;
      pos_r    <= pos_nxt;
      bstart_r <= bstart_nxt;
      blen_r   <= blen_nxt;
      done_r   <= done_nxt;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (res_push) oq_r[owr_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (res_push)        owr_r <= ~owr_r;
      if (pop && !empty)   ord_r <= ~ord_r;
      ocnt_r <= ocnt_r + {1'b0, res_push} - {1'b0, pop && !empty};
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r != 2'd3) else $error("result queue overflow");

  a_push_data: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (cmd_take && is_data)) else $error("result without data item");

  a_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
    !alive_r[L-1]) else $error("last cell kept alive");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ofull |-> !res_push) else $error("result pushed into full queue");

endmodule

`default_nettype wire

// ----- design/multi_pattern_substring_search.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_substring_search: streamed multi-variant substring search
// Top level: register file, input queue and search engine.
// ----------------------------------------------------------------------------
// Pattern bytes and lengths are loaded by items with opcodes load and length;
// data items then stream the range one byte per transfer. All window cells are
// classed against all variants in parallel, so the sustained rate is one item
// per clock unless a data item waits, which it does only while both result
// queue entries are occupied. A two-entry queue sits on each side, so input
// transfers continue while a result waits to be popped. One result appears per
// range (at range end, or earlier when a forward search is decided or hits a
// missing byte). The user must write registers through cfg_* only while the
// block is idle; the block does not enforce this. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_substring_search import msss_pkg::*; #(
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
  parameter int MAX_CONDS       = MAX_CONDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item,
  // result channel
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_item,
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t cfg_r;
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.case_sensitive  <= 1'b0;
      cfg_r.search_backward <= 1'b0;
      cfg_r.variant_count   <= 3'd1;
      cfg_r.range_start     <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CASE:   cfg_r.case_sensitive  <= cfg_data[0];
        CFG_BACK:   cfg_r.search_backward <= cfg_data[0];
        CFG_VCOUNT: cfg_r.variant_count   <= cfg_data[2:0];
        CFG_RSTART: cfg_r.range_start     <= cfg_data;
        default:    cfg_r                 <= cfg_r;
      endcase
    end
  end

  // front: accept and decode
  msss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: search and result queue
  msss_back #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .MAX_CONDS       (MAX_CONDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- sim/multi_pattern_substring_search_tb.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_substring_search_tb: self-checking bench for the search block
// Loads pattern variants, streams byte ranges and compares every search result
// against a behavioral predictor, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_pattern_substring_search_tb;
  import msss_pkg::*;

  localparam int PAT_LEN   = MAX_PATTERN_LEN_DEF;
  localparam int NUM_VAR   = MAX_CONDS_DEF;
  localparam int WDOG_MAX  = 2000;
  localparam int DRAIN_CYC = 20;

  // match classes of one byte at one window offset
  typedef enum logic [1:0] {CLS_MISS, CLS_CONT, CLS_LAST} byte_class_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  multi_pattern_substring_search dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: pattern tables, variant lengths, window and registers
  // ---------------------------------------------------------------------------
  logic [7:0]  pat_exact [NUM_VAR*PAT_LEN];
  logic [7:0]  pat_upper [NUM_VAR*PAT_LEN];
  logic [7:0]  pat_lower [NUM_VAR*PAT_LEN];
  logic [5:0]  var_len   [NUM_VAR];
  logic [PAT_LEN-1:0] live_align;
  logic [31:0] byte_pos, best_start;
  logic [5:0]  best_len;
  logic        range_decided;
  logic        p_case, p_back;
  logic [2:0]  p_vcount;
  logic [31:0] p_rstart;

  out_item_t   result_q[$];   // expected search results, oldest first
  int          n_errors = 0;
  int          wdog = 0;

  function automatic byte_class_e class_byte(logic [7:0] b, int d);
    int n;
    int idx;
    bit hit;
    n = (p_vcount > NUM_VAR) ? NUM_VAR : p_vcount;
    for (int v = 0; v < n; v++) begin
      if (var_len[v] == 0 || d >= var_len[v]) continue;
      idx = v * PAT_LEN + d;
      hit = p_case ? (pat_exact[idx] == b)
                   : (pat_upper[idx] == b || pat_lower[idx] == b);
      if (hit) return (d == var_len[v] - 1) ? CLS_LAST : CLS_CONT;
    end
    return CLS_MISS;
  endfunction

  function automatic void clear_window();
    live_align = '0;
    byte_pos = '0;
    best_start = '0;
    best_len = '0;
    range_decided = 1'b0;
  endfunction

  function automatic void push_result(bit ok);
    out_item_t r;
    r.found = ok;
    r.match_offset = ok ? p_rstart + best_start : '0;
    r.match_length = ok ? best_len : '0;
    result_q.push_back(r);
  endfunction

  // advance the predictor by one accepted item
  function automatic void predict_search(in_item_t it);
    logic [PAT_LEN-1:0] nxt;
    bit live;
    byte_class_e c;
    logic [31:0] s;
    int idx;
    case (it.opcode)
      OP_LOAD: begin
        idx = it.variant_index * PAT_LEN + it.char_index;
        pat_exact[idx] = it.exact_char;
        pat_upper[idx] = it.upper_char;
        pat_lower[idx] = it.lower_char;
      end
      OP_LEN: var_len[it.variant_index] = it.variant_length;
      OP_DATA: begin
        if (range_decided) begin
          if (it.range_last) clear_window();
        end else if (it.data_missing) begin
          if (!p_back) begin
            push_result(0);
            if (it.range_last) clear_window();
            else range_decided = 1'b1;
          end else begin
            live_align = '0;
            best_start = '0;
            best_len = '0;
            byte_pos++;
            if (it.range_last) begin
              push_result(0);
              clear_window();
            end
          end
        end else begin
          nxt = '0;
          for (int d = PAT_LEN - 1; d >= 0; d--) begin
            live = (d == 0) ? (p_back || best_len == 0) : live_align[d-1];
            if (!live) continue;
            c = class_byte(it.data_byte, d);
            if (c == CLS_CONT) begin
              if (d + 1 < PAT_LEN) nxt[d] = 1'b1;
            end else if (c == CLS_LAST) begin
              s = byte_pos - d;
              if (!p_back) begin
                best_start = s;
                best_len = 6'(d + 1);
                break;
              end
              if (best_len == 0 || s > best_start) begin
                best_start = s;
                best_len = 6'(d + 1);
              end
            end
          end
          live_align = nxt;
          byte_pos++;
          if (it.range_last) begin
            push_result(best_len != 0);
            clear_window();
          end else if (!p_back && best_len != 0 && live_align == '0) begin
            push_result(1);
            range_decided = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // one input transfer, with a random idle gap before it; push stays high
  // after the transfer until the next call or wait_idle takes it down
  task automatic send_item(in_item_t it);
    int gap;
    gap = $urandom_range(0, 8) * ($urandom_range(0, 3) != 0);
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      push <= 1'b0;
      wait_cycles(gap);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    predict_search(it);
  endtask

  // cfg_valid is dropped by the next send_item
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CASE:   p_case = val[0];
      CFG_BACK:   p_back = val[0];
      CFG_VCOUNT: p_vcount = val[2:0];
      default:    p_rstart = val;
    endcase
  endtask

  // let every expected result drain, then give the engine time to settle
  task automatic wait_idle();
    push <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    wait_cycles(DRAIN_CYC);
  endtask

  function automatic in_item_t mk_load(int v, int ci, logic [7:0] e, logic [7:0] u,
                                       logic [7:0] l);
    in_item_t it;
    it = in_item_t'($urandom());
    it.opcode = OP_LOAD;
    it.variant_index = 2'(v);
    it.char_index = 5'(ci);
    it.exact_char = e;
    it.upper_char = u;
    it.lower_char = l;
    return it;
  endfunction

  function automatic in_item_t mk_len(int v, logic [5:0] n);
    in_item_t it;
    it = in_item_t'($urandom());
    it.opcode = OP_LEN;
    it.variant_index = 2'(v);
    it.variant_length = n;
    return it;
  endfunction

  function automatic in_item_t mk_data(logic [7:0] b, bit miss, bit last);
    in_item_t it;
    it = in_item_t'({$urandom(), $urandom()});
    it.opcode = OP_DATA;
    it.data_byte = b;
    it.data_missing = miss;
    it.range_last = last;
    return it;
  endfunction

  // fill every table entry so no read ever hits an unwritten one
  task automatic load_all_patterns(int alpha);
    logic [7:0] e;
    for (int v = 0; v < NUM_VAR; v++)
      for (int ci = 0; ci < PAT_LEN; ci++) begin
        e = 8'(8'h41 + $urandom_range(0, alpha - 1));
        send_item(mk_load(v, ci, e, e, e | 8'h20));
      end
  endtask

  // one range of random bytes drawn from a small alphabet, with some
  // bytes copied from variant 0 so full matches show up
  task automatic send_range(int n, int alpha);
    logic [7:0] b;
    int k;
    k = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0 && var_len[0] != 0 && var_len[0] <= PAT_LEN) begin
        b = pat_exact[k];
        k = (k + 1) % var_len[0];
      end else begin
        b = 8'(8'h41 + $urandom_range(0, alpha - 1));
        if ($urandom_range(0, 3) == 0) b = b | 8'h20;
        if ($urandom_range(0, 30) == 0) b = 8'($urandom());
      end
      send_item(mk_data(b, $urandom_range(0, 40) == 0, i == n - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: preset patterns, then short ranges
  // ---------------------------------------------------------------------------
  typedef struct {
    in_item_t  item;
    bit        chk;     // typed-in expectation present
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(in_item_t it, bit chk = 0, out_item_t want = '0);
    dir_row_t r;
    r.item = it;
    r.chk = chk;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: random pop stall, field-by-field compare
  // ---------------------------------------------------------------------------
  int pop_gap = 0;
  out_item_t want_r;

  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (result_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result: found=%0d offset=%0h length=%0d",
                     out_item.found, out_item.match_offset, out_item.match_length);
        end else begin
          want_r = result_q.pop_front();
          if (out_item.found !== want_r.found ||
              out_item.match_offset !== want_r.match_offset ||
              out_item.match_length !== want_r.match_length) begin
            n_errors++;
            if (n_errors <= 10)
              $display("result mismatch: expected %0d/%0h/%0d got %0d/%0h/%0d",
                       want_r.found, want_r.match_offset, want_r.match_length,
                       out_item.found, out_item.match_offset, out_item.match_length);
          end
        end
        pop_gap <= $urandom_range(0, 8) * ($urandom_range(0, 3) != 0);
        pop <= 1'b0;
      end else if (pop_gap != 0) begin
        pop_gap <= pop_gap - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n ||
        (!push && result_q.size() == 0))
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  out_item_t w;

  initial begin
    for (int i = 0; i < NUM_VAR; i++) var_len[i] = LEN_RESET;
    p_case = 0;
    p_back = 0;
    p_vcount = 1;
    p_rstart = 0;
    clear_window();
    wait_cycles(4);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers in reset state; pattern "AB" as variant 0
    add_row(mk_load(0, 0, 8'h41, 8'h41, 8'h61));
    add_row(mk_load(0, 1, 8'h42, 8'h42, 8'h62));
    add_row(mk_len(0, 6'd2));
    // "xab": case-insensitive match at start 1
    add_row(mk_data(8'h78, 0, 0));
    add_row(mk_data(8'h61, 0, 0));
    w = '{found: 1'b1, match_offset: 32'd1, match_length: 6'd2};
    add_row(mk_data(8'h62, 0, 0), 1, w);
    add_row(mk_data(8'h00, 0, 1));
    // missing byte in forward mode: not found at once
    add_row(mk_data(8'h41, 1, 0), 1, '0);
    add_row(mk_data(8'h42, 0, 1));
    // range with no match: not found at the end
    add_row(mk_data(8'hFF, 0, 0));
    add_row(mk_data(8'h41, 0, 1), 1, '0);
    // edge items: last char of variant 3, zero length, longest length field
    add_row(mk_load(3, 31, 8'hFF, 8'hFF, 8'hFF));
    add_row(mk_len(3, 6'd0));
    add_row(mk_len(1, 6'd63));
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item);
      if (dir_rows[i].chk) begin
        if (result_q.size() == 0 || result_q[$] != dir_rows[i].want) begin
          n_errors++;
          if (n_errors <= 10) $display("directed row %0d: predictor disagrees", i);
        end
      end
    end
    wait_idle();

    // preset every table entry, then walk register settings
    load_all_patterns(3);
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_reg(CFG_CASE, ph[0]);
      write_reg(CFG_BACK, ph[1]);
      write_reg(CFG_VCOUNT, (ph == 0) ? 3'd0 : (ph == 7) ? 3'd7 : $urandom_range(1, 4));
      write_reg(CFG_RSTART, (ph == 3) ? 32'hFFFF_FFF0 : (ph == 5) ? 32'h0 : $urandom());
      for (int v = 0; v < NUM_VAR; v++)
        send_item(mk_len(v, (ph == 6 && v == 3) ? 6'd40 : 6'($urandom_range(1, 4))));
      for (int r = 0; r < 9; r++) begin
        send_range($urandom_range(1, 10), 3);
        if (r == 5) wait_idle();   // sender holds until results drained
      end
      // a few pattern rewrites with fresh content
      for (int k = 0; k < 4; k++) begin
        send_item(mk_load($urandom_range(0, 3), $urandom_range(0, 31),
                          8'(8'h41 + $urandom_range(0, 2)),
                          8'(8'h41 + $urandom_range(0, 2)),
                          8'(8'h61 + $urandom_range(0, 2))));
      end
    end
    // long pattern reaching the full window
    wait_idle();
    write_reg(CFG_VCOUNT, 3'd1);
    send_item(mk_len(0, 6'd32));
    send_range(40, 1);
    send_item(mk_len(0, 6'd1));
    send_range(3, 1);

    wait_idle();
    if (n_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
